// ===== hdl/vpr_pkg.sv =====
// Shared constants, arctangent table and saturation helper for the polar-to-rectangular block.
package vpr_pkg;

	localparam int ROT_STAGES = 16;

	localparam int ANGLE_W = 16;
	localparam int SPEED_W = 16;
	localparam int RATE_W  = 17;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	// Internal datapath widths: x and y in Q.22, z in Q.30 radians.
	localparam int XW        = 37;
	localparam int ZW        = 34;
	localparam int GAIN_W    = 30;
	localparam int ANG_SHIFT = 17;
	localparam int RND_SHIFT = 18;
	localparam int RND_W     = XW + 1 - RND_SHIFT;
	localparam int PROD_W    = SPEED_W + GAIN_W;
	localparam int X0_SHIFT  = 12;

	localparam logic [GAIN_W-1:0]    GAIN_Q30    = 30'd652032874;
	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [XW:0]   ROUND_HALF  = 38'sd131072;

	localparam logic signed [RATE_W-1:0] RATE_MAX = 17'sd65535;
	localparam logic signed [RATE_W-1:0] RATE_MIN = -17'sd65535;

	localparam logic [SPEED_W-1:0]       SPEED_RESET = 16'd1600;
	localparam logic [ADDR_W-3:0]        REG_SPEED   = '0;

	// atan(2^-i) in Q.30, truncated.
	function automatic logic [31:0] atan_q30(input int idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			24: r = 32'h0000003F;
			25: r = 32'h0000001F;
			26: r = 32'h0000000F;
			27: r = 32'h00000007;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [RND_W-1:0] v);
		logic signed [RATE_W-1:0] r;
		if (v > RND_W'(RATE_MAX)) begin
			r = RATE_MAX;
		end else if (v < RND_W'(RATE_MIN)) begin
			r = RATE_MIN;
		end else begin
			r = v[RATE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/vpr_angle_if.sv =====
// Angle input channel: valid/ready handshake carrying one attitude angle.
interface vpr_angle_if;
	import vpr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] attitude_angle;

	modport source (output valid, output attitude_angle, input ready);
	modport sink (input valid, input attitude_angle, output ready);
endinterface

// ===== hdl/vpr_rate_if.sv =====
// Rate output channel: valid/ready handshake carrying the two velocity components.
interface vpr_rate_if;
	import vpr_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] forward_rate;
	logic signed [RATE_W-1:0] vertical_rate;

	modport source (output valid, output forward_rate, output vertical_rate, input ready);
	modport sink (input valid, input forward_rate, input vertical_rate, output ready);
endinterface

// ===== hdl/velocity_polar_to_rect.sv =====
// Pipelined CORDIC that resolves the configured speed along a pitch angle.
// The stages are one entry stage with the quadrant fold and gain multiply, one register per
// rotation stage, a rounding stage and the output register. Throughput is one angle per
// cycle while the output is not stalled; each stage advances on its own when it is empty
// or its successor moves, so bubbles close up behind a stalled output.
// Reset clears every valid bit and loads speed with 1600 (100.0 m/s).
module velocity_polar_to_rect (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vpr_pkg::ADDR_W-1:0]   paddr,
	input  logic [vpr_pkg::DATA_W-1:0]   pwdata,
	output logic [vpr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	vpr_angle_if.sink                    angle,
	vpr_rate_if.source                   rate
);
	import vpr_pkg::*;

	// Configuration register.
	logic [SPEED_W-1:0] speed_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
		end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_SPEED) begin
			speed_q <= pwdata[SPEED_W-1:0];
		end
	end

	always_comb begin
		if (paddr[ADDR_W-1:2] == REG_SPEED) begin
			prdata = {{(DATA_W-SPEED_W){1'b0}}, speed_q};
		end else begin
			prdata = '0;
		end
	end

	// Rotation pipeline; entry 0 is the fold/multiply stage.
	logic signed [XW-1:0] rot_x_s [0:ROT_STAGES];
	logic signed [XW-1:0] rot_y_s [0:ROT_STAGES];
	logic signed [ZW-1:0] rot_z_s [0:ROT_STAGES];
	logic                 rot_f_s [0:ROT_STAGES];
	logic                 rot_v_s [0:ROT_STAGES];
	logic                 rot_adv [0:ROT_STAGES];

	logic                     rnd_v_sr;
	logic                     rnd_f_sr;
	logic signed [RND_W-1:0]  fwd_sr;
	logic signed [RND_W-1:0]  vert_sr;
	logic                     rnd_adv;

	logic                     out_v_so;
	logic signed [RATE_W-1:0] fwd_so;
	logic signed [RATE_W-1:0] vert_so;
	logic                     out_adv;

	assign out_adv = !out_v_so || rate.ready;
	assign rnd_adv = !rnd_v_sr || out_adv;
	assign angle.ready = rot_adv[0];

	// Entry stage: bring the angle into -pi/2..pi/2 and scale speed by the CORDIC gain.
	logic signed [ZW-1:0] z_raw;
	logic signed [ZW-1:0] z_fold;
	logic                 flip;
	logic [PROD_W-1:0]    gain_prod;

	assign z_raw = {{(ZW-ANGLE_W-ANG_SHIFT){angle.attitude_angle[ANGLE_W-1]}},
		angle.attitude_angle, {ANG_SHIFT{1'b0}}};
	assign gain_prod = PROD_W'(speed_q) * PROD_W'(GAIN_Q30);

	always_comb begin
		if (z_raw > HALF_PI_Q30) begin
			z_fold = z_raw - PI_Q30;
			flip   = 1'b1;
		end else if (z_raw < -HALF_PI_Q30) begin
			z_fold = z_raw + PI_Q30;
			flip   = 1'b1;
		end else begin
			z_fold = z_raw;
			flip   = 1'b0;
		end
	end

	assign rot_adv[0] = !rot_v_s[0] || rot_adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v_s[0] <= 1'b0;
		end else if (rot_adv[0]) begin
			rot_v_s[0] <= angle.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rot_adv[0] && angle.valid) begin
			rot_x_s[0] <= {{(XW-(PROD_W-X0_SHIFT)){1'b0}}, gain_prod[PROD_W-1:X0_SHIFT]};
			rot_y_s[0] <= '0;
			rot_z_s[0] <= z_fold;
			rot_f_s[0] <= flip;
		end
	end

	// One micro-rotation per stage with shift amount equal to the stage number.
	for (genvar i = 0; i < ROT_STAGES; i++) begin : g_rot
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;
		logic signed [ZW-1:0] da;

		assign dx = rot_y_s[i] >>> i;
		assign dy = rot_x_s[i] >>> i;
		assign da = {{(ZW-32){1'b0}}, atan_q30(i)};

		if (i + 1 < ROT_STAGES) begin : g_mid
			assign rot_adv[i+1] = !rot_v_s[i+1] || rot_adv[i+2];
		end else begin : g_last
			assign rot_adv[i+1] = !rot_v_s[i+1] || rnd_adv;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_v_s[i+1] <= 1'b0;
			end else if (rot_adv[i+1]) begin
				rot_v_s[i+1] <= rot_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rot_adv[i+1] && rot_v_s[i]) begin
				rot_f_s[i+1] <= rot_f_s[i];
				if (!rot_z_s[i][ZW-1]) begin
					rot_x_s[i+1] <= rot_x_s[i] - dx;
					rot_y_s[i+1] <= rot_y_s[i] + dy;
					rot_z_s[i+1] <= rot_z_s[i] - da;
				end else begin
					rot_x_s[i+1] <= rot_x_s[i] + dx;
					rot_y_s[i+1] <= rot_y_s[i] - dy;
					rot_z_s[i+1] <= rot_z_s[i] + da;
				end
			end
		end
	end

	// Rounding stage: half-up rounding from Q.22 to Q.4; the vertical part is negated here.
	logic signed [XW:0] fwd_sum;
	logic signed [XW:0] vert_sum;

	assign fwd_sum  = {rot_x_s[ROT_STAGES][XW-1], rot_x_s[ROT_STAGES]} + ROUND_HALF;
	assign vert_sum = ROUND_HALF - {rot_y_s[ROT_STAGES][XW-1], rot_y_s[ROT_STAGES]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_v_sr <= 1'b0;
		end else if (rnd_adv) begin
			rnd_v_sr <= rot_v_s[ROT_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (rnd_adv && rot_v_s[ROT_STAGES]) begin
			fwd_sr   <= fwd_sum[XW:RND_SHIFT];
			vert_sr  <= vert_sum[XW:RND_SHIFT];
			rnd_f_sr <= rot_f_s[ROT_STAGES];
		end
	end

	// Output register: undo the quadrant fold, then saturate.
	logic signed [RND_W-1:0] fwd_fix;
	logic signed [RND_W-1:0] vert_fix;

	assign fwd_fix  = rnd_f_sr ? -fwd_sr : fwd_sr;
	assign vert_fix = rnd_f_sr ? -vert_sr : vert_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_so <= 1'b0;
		end else if (out_adv) begin
			out_v_so <= rnd_v_sr;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && rnd_v_sr) begin
			fwd_so  <= sat_rate(fwd_fix);
			vert_so <= sat_rate(vert_fix);
		end
	end

	assign rate.valid         = out_v_so;
	assign rate.forward_rate  = fwd_so;
	assign rate.vertical_rate = vert_so;

	// An accepted angle always lands in the entry stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(angle.valid && angle.ready) |=> rot_v_s[0])
		else $error("accepted angle did not enter the pipeline");

	// A rounded result that moves on must show up at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rnd_v_sr && out_adv) |=> rate.valid)
		else $error("rounded result lost before the output register");

	// Saturation keeps both components symmetric about zero; only the lower limit is checked here.
	assert property (@(posedge clk) disable iff (!arst_n)
		rate.valid |-> (rate.forward_rate >= RATE_MIN && rate.vertical_rate >= RATE_MIN))
		else $error("output below the saturation limit");

endmodule
